// ===== sv/csti_pkg.sv =====
package csti_pkg;

	// alphabet storage and limits
	localparam int SYM_COUNT   = 32;
	localparam int MAX_SYMBOLS = 32;
	localparam int SYM_LIMIT   = (MAX_SYMBOLS < SYM_COUNT) ? MAX_SYMBOLS : SYM_COUNT;
	localparam int IDX_W       = $clog2(SYM_COUNT);
	localparam int BASE_W      = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYM_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYM_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYM_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYM_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd4;

	// special characters
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	typedef logic [SYM_COUNT-1:0][7:0] sym_vec_t;

	// one classified character, passed from front to back
	typedef struct packed {
		logic              blank;
		logic              plus;
		logic              minus;
		logic              digit;
		logic [IDX_W-1:0]  idx;
		logic [BASE_W-1:0] base;
		logic              ok;
		logic              last;
	} item_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
	endfunction

endpackage

// ===== sv/csti_front.sv =====
module csti_front (
	input  logic [7:0]                  character,
	input  logic                        last,
	input  csti_pkg::sym_vec_t          sym,
	input  logic [csti_pkg::BASE_W-1:0] base_size,
	output csti_pkg::item_t             item
);
	import csti_pkg::*;

	logic [SYM_COUNT-1:0] in_use;
	logic [SYM_COUNT-1:0] hit;
	logic [IDX_W-1:0]     idx;
	logic                 bad_sym;
	logic                 dup;
	logic                 size_ok;

	// symbols in use, clamped to the storage limit
	always_comb begin
		for (int k = 0; k < SYM_COUNT; k++) begin
			in_use[k] = (BASE_W'(k) < base_size) && (k < SYM_LIMIT);
		end
	end

	// parallel symbol match, lowest index wins
	always_comb begin
		idx = '0;
		for (int k = SYM_COUNT - 1; k >= 0; k--) begin
			hit[k] = in_use[k] && (sym[k] == character);
			if (hit[k]) begin
				idx = IDX_W'(k);
			end
		end
	end

	// alphabet checks on the current configuration
	always_comb begin
		bad_sym = 1'b0;
		dup     = 1'b0;
		for (int i = 0; i < SYM_COUNT; i++) begin
			if (in_use[i] && (sym[i] == CHAR_NUL || sym[i] == CHAR_PLUS ||
					sym[i] == CHAR_MINUS || is_blank(sym[i]))) begin
				bad_sym = 1'b1;
			end
			for (int j = i + 1; j < SYM_COUNT; j++) begin
				if (in_use[j] && sym[i] == sym[j]) begin
					dup = 1'b1;
				end
			end
		end
		size_ok = (base_size >= BASE_W'(2)) && (base_size <= BASE_W'(SYM_LIMIT));
	end

	// classified transaction
	always_comb begin
		item.blank = is_blank(character);
		item.plus  = (character == CHAR_PLUS);
		item.minus = (character == CHAR_MINUS);
		item.digit = |hit;
		item.idx   = idx;
		item.base  = base_size;
		item.ok    = size_ok && !bad_sym && !dup;
		item.last  = last;
	end

endmodule

// ===== sv/csti_fifo.sv =====
module csti_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csti_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output csti_pkg::item_t pop_item
);
	import csti_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/csti_back.sv =====
module csti_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  csti_pkg::item_t    item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic               base_valid
);
	import csti_pkg::*;

	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_STOP   = 2'd3;

	logic [1:0]  phase_q;
	logic        parity_q;
	logic [31:0] acc_q;
	logic        out_valid_q;
	logic [31:0] value_q;
	logic        base_valid_q;

	logic [1:0]  ph;
	logic        par;
	logic [31:0] acc;
	logic        out_free;

	// take an item unless its result has nowhere to go
	assign out_free = !out_valid_q || out_ready;
	assign pop      = item_valid && (!item.last || out_free);

	// parse step with multiply-add
	always_comb begin
		ph  = phase_q;
		par = parity_q;
		acc = acc_q;
		if (ph == PH_SKIP && !item.blank) begin
			ph = PH_SIGN;
		end
		if (ph == PH_SIGN) begin
			if (item.minus) begin
				par = ~par;
			end else if (!item.plus) begin
				ph = PH_DIGITS;
			end
		end
		if (ph == PH_DIGITS) begin
			if (item.digit) begin
				acc = acc_q * 32'(item.base) + 32'(item.idx);
			end else begin
				ph = PH_STOP;
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			parity_q <= 1'b0;
			acc_q    <= '0;
		end else if (pop) begin
			if (item.last) begin
				phase_q  <= PH_SKIP;
				parity_q <= 1'b0;
				acc_q    <= '0;
			end else begin
				phase_q  <= ph;
				parity_q <= par;
				acc_q    <= acc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && item.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			base_valid_q <= item.ok;
			if (!item.ok) begin
				value_q <= '0;
			end else if (par) begin
				value_q <= 32'd0 - acc;
			end else begin
				value_q <= acc;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = signed'(value_q);
	assign base_valid = base_valid_q;

endmodule

// ===== sv/custom_base_string_to_integer.sv =====
// string to integer in a configurable alphabet, one character per transaction
// a result is registered when the back pops the item carrying last, which waits in the queue until the output is free
// throughput: 1 character per cycle while in_ready is high, with the multiply-add in the back combinational
// a 2-entry queue between classifier and parser absorbs output stalls
// reset: async active low, clears parse state, queue, output valid and all config registers
module custom_base_string_to_integer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [csti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csti_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      character,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [31:0]              value,
	output logic                            base_valid
);
	import csti_pkg::*;

	logic [3:0][63:0]  sym_q;
	logic [BASE_W-1:0] base_size_q;
	sym_vec_t          sym;
	item_t             front_item;
	item_t             back_item;
	logic              fifo_full;
	logic              fifo_not_empty;
	logic              fifo_pop;
	logic              fifo_push;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q       <= '0;
			base_size_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_SYM_0_7:   sym_q[0]    <= cfg_data;
				CFG_SYM_8_15:  sym_q[1]    <= cfg_data;
				CFG_SYM_16_23: sym_q[2]    <= cfg_data;
				CFG_SYM_24_31: sym_q[3]    <= cfg_data;
				CFG_BASE:      base_size_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	assign sym       = sym_q;
	assign in_ready  = !fifo_full;
	assign fifo_push = in_valid && !fifo_full;

	// classify incoming characters
	csti_front u_front (
		.character (character),
		.last      (last),
		.sym       (sym),
		.base_size (base_size_q),
		.item      (front_item)
	);

	// decoupling queue
	csti_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_item (front_item),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.not_empty (fifo_not_empty),
		.pop_item  (back_item)
	);

	// parse and deliver results
	csti_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (fifo_not_empty),
		.item       (back_item),
		.pop        (fifo_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.base_valid (base_valid)
	);

endmodule

// ===== test/custom_base_string_to_integer_tb.sv =====
`timescale 1ns / 100ps

module custom_base_string_to_integer_tb;
	import csti_pkg::*;

	localparam int DRAIN_CYCLES = 6;
	localparam int QUIET_LIMIT  = 5000;

	typedef enum logic [1:0] {SKIP_BLANK, READ_SIGN, READ_DIGIT, STOPPED} parse_phase_t;
	typedef enum int {DUP_SYMBOL, RESERVED_SYMBOL, SIZE_TOO_SMALL, SIZE_TOO_LARGE} corrupt_t;

	typedef struct packed {
		logic signed [31:0] number;
		logic               base_valid;
	} parse_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            character;
	logic                  last;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [31:0]    value;
	logic                  base_valid;

	// mirror of the alphabet registers and of the parse state
	sym_vec_t              sym_mirror;
	logic [BASE_W-1:0]     base_mirror;
	parse_phase_t          phase_now;
	logic                  negative;
	logic [31:0]           acc;

	parse_result_t         expected_q [$];
	logic [7:0]            text_buf [$];
	int                    send_idle_pct = 0;
	int                    stall_pct = 0;
	int                    chars_sent = 0;
	int                    mismatch_count = 0;

	custom_base_string_to_integer DUT (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic blank_char(input logic [7:0] c);
		return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
	endfunction

	function automatic logic usable_symbol(input logic [7:0] c);
		return !(c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || blank_char(c));
	endfunction

	function automatic logic alphabet_ok();
		int n;
		n = base_mirror;
		if (n < 2 || n > SYM_LIMIT)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!usable_symbol(sym_mirror[i]))
				return 1'b0;
			for (int j = i + 1; j < n; j++)
				if (sym_mirror[j] == sym_mirror[i])
					return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void clear_parse_state();
		phase_now = SKIP_BLANK;
		negative  = 1'b0;
		acc       = '0;
	endfunction

	// advance the parse by one accepted character, queue the number on last
	function automatic void take_char(input logic [7:0] c, input logic l);
		int in_use;
		logic hit;
		logic [31:0] idx;
		parse_result_t res;
		in_use = (base_mirror > SYM_LIMIT) ? SYM_LIMIT : base_mirror;
		if (phase_now == SKIP_BLANK && !blank_char(c))
			phase_now = READ_SIGN;
		if (phase_now == READ_SIGN) begin
			if (c == CHAR_MINUS)
				negative = ~negative;
			else if (c != CHAR_PLUS)
				phase_now = READ_DIGIT;
		end
		if (phase_now == READ_DIGIT) begin
			hit = 1'b0;
			idx = '0;
			for (int i = 0; i < in_use; i++)
				if (!hit && sym_mirror[i] == c) begin
					hit = 1'b1;
					idx = i;
				end
			if (hit)
				acc = acc * 32'(base_mirror) + idx;
			else
				phase_now = STOPPED;
		end
		if (l) begin
			res.base_valid = alphabet_ok();
			res.number = res.base_valid ? (negative ? -acc : acc) : '0;
			expected_q.push_back(res);
			clear_parse_state();
		end
	endfunction

	function automatic logic [7:0] pick_blank();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] pick_reserved();
		int k;
		k = $urandom_range(3);
		case (k)
			0: return CHAR_NUL;
			1: return CHAR_PLUS;
			2: return CHAR_MINUS;
			default: return pick_blank();
		endcase
	endfunction

	// consecutive symbols from first, unused slots zero
	function automatic sym_vec_t seq_symbols(input logic [7:0] first, input int n);
		sym_vec_t v;
		for (int i = 0; i < SYM_COUNT; i++)
			v[i] = (i < n) ? first + 8'(i) : CHAR_NUL;
		return v;
	endfunction

	// n distinct usable symbols, random bytes in the unused slots
	function automatic sym_vec_t random_symbols(input int n);
		sym_vec_t v;
		logic [255:0] taken;
		logic [7:0] c;
		taken = '0;
		for (int i = 0; i < SYM_COUNT; i++)
			v[i] = 8'($urandom_range(255));
		for (int i = 0; i < n; i++) begin
			do
				c = 8'($urandom_range(255));
			while (taken[c] || !usable_symbol(c));
			taken[c] = 1'b1;
			v[i] = c;
		end
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatch_count < 40)
			$display("mismatch: %s, expected %h, got %h", what, want, got);
		mismatch_count++;
	endtask

	// one character transaction, with a random gap before it
	task automatic send_char(input logic [7:0] c, input logic l);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid  <= 1'b1;
		character <= c;
		last      <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
		take_char(c, l);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// hold the sender until every expected number has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_alphabet(input sym_vec_t v, input logic [BASE_W-1:0] n);
		logic [63:0] upper;
		wait_idle();
		upper = {$urandom, $urandom};
		cfg_write_en <= 1'b1;
		cfg_index    <= CFG_SYM_0_7;
		cfg_data     <= v[0 +: 8];
		@(posedge clk);
		cfg_index    <= CFG_SYM_8_15;
		cfg_data     <= v[8 +: 8];
		@(posedge clk);
		cfg_index    <= CFG_SYM_16_23;
		cfg_data     <= v[16 +: 8];
		@(posedge clk);
		cfg_index    <= CFG_SYM_24_31;
		cfg_data     <= v[24 +: 8];
		@(posedge clk);
		cfg_index    <= CFG_BASE;
		cfg_data     <= {upper[63:BASE_W], n};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sym_mirror  = v;
		base_mirror = n;
	endtask

	task automatic load_random_alphabet();
		sym_vec_t v;
		int n, i, j;
		n = $urandom_range(2, SYM_COUNT);
		v = random_symbols(n);
		if ($urandom_range(99) >= 85) begin
			case (corrupt_t'($urandom_range(3)))
				DUP_SYMBOL: begin
					i = $urandom_range(n - 1);
					j = (i + 1 + $urandom_range(n - 2)) % n;
					v[j] = v[i];
				end
				RESERVED_SYMBOL: v[$urandom_range(n - 1)] = pick_reserved();
				SIZE_TOO_SMALL: n = $urandom_range(1);
				default: begin
					v = random_symbols(SYM_COUNT);
					n = $urandom_range(SYM_COUNT + 1, 63);
				end
			endcase
		end
		load_alphabet(v, BASE_W'(n));
	endtask

	// mostly well-formed numbers, some plain noise
	task automatic send_random_string();
		int in_use, k;
		in_use = (base_mirror > SYM_LIMIT) ? SYM_LIMIT : base_mirror;
		text_buf.delete();
		if (in_use > 0 && $urandom_range(99) < 80) begin
			repeat ($urandom_range(2)) text_buf.push_back(pick_blank());
			repeat ($urandom_range(3))
				text_buf.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
			k = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(6);
			repeat (k) text_buf.push_back(sym_mirror[$urandom_range(in_use - 1)]);
			repeat ($urandom_range(2)) text_buf.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
		end
		if (text_buf.size() == 0)
			text_buf.push_back(8'($urandom_range(255)));
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	// alphabet left as reset: empty, so always invalid
	task automatic test_reset_alphabet();
		send_string(" -5");
		send_char(CHAR_NUL, 1'b1);
	endtask

	// blank skipping, sign parity, stop rules in decimal
	task automatic test_parse_rules();
		load_alphabet(seq_symbols("0", 10), 6'd10);
		send_string("\011\012\013\014\015 +-+-7");
		send_string("-0");
		send_string("-");
		send_char("9", 1'b0);
		send_char(CHAR_NUL, 1'b0);
		send_char("5", 1'b1);
		send_string("4x2");
	endtask

	// smallest and largest radix, wrap past 32 bits
	task automatic test_radix_extremes();
		load_alphabet(seq_symbols("0", 2), 6'd2);
		send_string("-11");
		load_alphabet(seq_symbols(8'hE0, SYM_COUNT), 6'd32);
		repeat (6) send_char(8'hFF, 1'b0);
		send_char(8'hFF, 1'b1);
	endtask

	task automatic probe_alphabet(input sym_vec_t v, input logic [BASE_W-1:0] n,
			input logic [7:0] c);
		load_alphabet(v, n);
		send_char(c, 1'b1);
	endtask

	// every way the alphabet can be rejected
	task automatic test_invalid_alphabets();
		sym_vec_t dec, v;
		dec = seq_symbols("0", 10);
		probe_alphabet(dec, 6'd0, "3");
		probe_alphabet(dec, 6'd1, "0");
		probe_alphabet(seq_symbols(8'hE0, SYM_COUNT), 6'd33, 8'hE3);
		probe_alphabet(seq_symbols(8'hE0, SYM_COUNT), 6'd63, 8'hFF);
		probe_alphabet('1, 6'd32, 8'hFF);
		probe_alphabet('0, 6'd0, CHAR_NUL);
		v = dec; v[7] = "3";
		probe_alphabet(v, 6'd10, "3");
		v = dec; v[9] = CHAR_PLUS;
		probe_alphabet(v, 6'd10, "3");
		v = dec; v[0] = CHAR_MINUS;
		probe_alphabet(v, 6'd10, "3");
		v = dec; v[4] = CHAR_SPACE;
		probe_alphabet(v, 6'd10, "3");
		v = dec; v[2] = CHAR_TAB;
		probe_alphabet(v, 6'd10, "3");
		v = dec; v[5] = CHAR_CR;
		probe_alphabet(v, 6'd10, "3");
		v = dec; v[8] = CHAR_NUL;
		probe_alphabet(v, 6'd10, "3");
	endtask

	task automatic test_random_strings(input int idle_pct, input int stall);
		int start;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		for (int a = 0; a < 4; a++) begin
			load_random_alphabet();
			start = chars_sent;
			while (chars_sent - start < 26) begin
				send_random_string();
				if ($urandom_range(19) == 0)
					wait_idle();
			end
		end
	endtask

	// compare each number transaction with the oldest expected one
	always @(posedge clk) begin : check_results
		parse_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("number with none expected", '0, value);
			end else begin
				want = expected_q.pop_front();
				if (value !== want.number)
					report_mismatch("value", want.number, value);
				if (base_valid !== want.base_valid)
					report_mismatch("base_valid", 32'(want.base_valid), 32'(base_valid));
			end
		end
	end

	// no transaction for too long ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = CFG_SYM_0_7;
		cfg_data     = '0;
		in_valid     = 1'b0;
		character    = '0;
		last         = 1'b0;
		sym_mirror   = '0;
		base_mirror  = '0;
		clear_parse_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_alphabet();
		test_parse_rules();
		test_radix_extremes();
		test_invalid_alphabets();
		test_random_strings(0, 0);
		test_random_strings(82, 0);
		test_random_strings(0, 82);
		test_random_strings(34, 34);

		stall_pct = 0;
		wait_idle();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
